### sv/ttsd_pkg.sv
// Shared constants, codes and types of the transition triple sort and dedup block.
package ttsd_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int FIELD_W      = 15;
    localparam int KEY_W        = 3 * FIELD_W;
    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 10;
    localparam int ROWC_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = ((3 * FIELD_W + INDEX_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((ROWC_W + 4 * FIELD_W + 7) / 8) * 8;

    localparam logic [FIELD_W-1:0] TOO_BIG      = '1;
    localparam logic [FIELD_W-1:0] EMPTY_STATES = FIELD_W'(2);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_REOPEN = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MODE  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

### sv/ttsd_cell.sv
// One cell of the insertion sort chain: keeps the smaller key and passes the larger one on.
module ttsd_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttsd_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_in_valid,
    input  ttsd_pkg::t_key       i_in_key,
    input  logic                 i_nb_full,
    input  ttsd_pkg::t_key       i_nb_key,
    output logic                 o_pass_valid,
    output ttsd_pkg::t_key       o_pass_key,
    output logic                 o_full,
    output ttsd_pkg::t_key       o_key
);

    logic           r_full;
    ttsd_pkg::t_key r_key;
    logic           r_pass_valid;
    ttsd_pkg::t_key r_pass_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= 1'b0;
            r_pass_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_full       <= 1'b0;
            r_pass_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_full       <= i_nb_full;
            r_key        <= i_nb_key;
            r_pass_valid <= 1'b0;
        end else if (i_in_valid) begin
            if (!r_full) begin
                r_full       <= 1'b1;
                r_key        <= i_in_key;
                r_pass_valid <= 1'b0;
            end else if (i_in_key < r_key) begin
                r_key        <= i_in_key;
                r_pass_key   <= r_key;
                r_pass_valid <= 1'b1;
            end else begin
                r_pass_key   <= i_in_key;
                r_pass_valid <= 1'b1;
            end
        end else begin
            r_pass_valid <= 1'b0;
        end
    end

    assign o_pass_valid = r_pass_valid;
    assign o_pass_key   = r_pass_key;
    assign o_full       = r_full;
    assign o_key        = r_key;

endmodule

### sv/ttsd_sorter.sv
// Chain of sort cells; the head cell holds the smallest key and shifting drains in order.
module ttsd_sorter #(
    parameter int NUM_CELLS = ttsd_pkg::MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttsd_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_in_valid,
    input  ttsd_pkg::t_key       i_in_key,
    output logic                 o_head_full,
    output ttsd_pkg::t_key       o_head_key
);

    logic           pass_valid [0:NUM_CELLS];
    ttsd_pkg::t_key pass_key   [0:NUM_CELLS];
    logic           full       [0:NUM_CELLS];
    ttsd_pkg::t_key key        [0:NUM_CELLS];

    assign pass_valid[0]    = i_in_valid;
    assign pass_key[0]      = i_in_key;
    assign full[NUM_CELLS]  = 1'b0;
    assign key[NUM_CELLS]   = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        ttsd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_in_valid  (pass_valid[g]),
            .i_in_key    (pass_key[g]),
            .i_nb_full   (full[g+1]),
            .i_nb_key    (key[g+1]),
            .o_pass_valid(pass_valid[g+1]),
            .o_pass_key  (pass_key[g+1]),
            .o_full      (full[g]),
            .o_key       (key[g])
        );
    end

    assign o_head_full = full[0];
    assign o_head_key  = key[0];

endmodule

### sv/transition_triple_sort_dedup.sv
// Top level: triple table with command decode, row memory, result register and sort sequencer.
// Adds, reads, reopens and closes that need no sort take one transaction per cycle. A single
// result register holds each result, and the next command is taken only in a cycle in which
// no result waits or the waiting one is taken. A close of an open, non-empty table holds
// off new commands while it sorts through the chain of MAX_ROWS sort cells: S_LOAD reads
// the rows into the chain at one memory read a cycle, S_SETTLE lets the last insertion
// ripple to its place, and S_DRAIN shifts the sorted rows out of the head cell and writes
// the unique ones back.
module transition_triple_sort_dedup #(
    parameter int MAX_ROWS = ttsd_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // from_state, label, to_state, row_index from bit 0 up, zero filled.
    input  logic [ttsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind.
    input  logic [ttsd_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // row_count, state_count, out_from_state, out_label, out_to_state from bit 0 up, zero filled.
    output logic [ttsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // status.
    output logic [ttsd_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int FW = ttsd_pkg::FIELD_W;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int IW = (CW > ttsd_pkg::INDEX_W) ? CW : ttsd_pkg::INDEX_W;
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] FULL_ROWS = CW'(MAX_ROWS);

    typedef enum logic [3:0] {
        S_RUN    = 4'b0001,
        S_LOAD   = 4'b0010,
        S_SETTLE = 4'b0100,
        S_DRAIN  = 4'b1000
    } t_state;

    t_state             r_state;
    logic               r_open;
    logic [CW-1:0]      r_rows;
    logic [FW-1:0]      r_states;
    logic [TW-1:0]      r_cnt;
    logic [CW-1:0]      r_w;
    ttsd_pkg::t_key     r_last;
    logic               r_ld_valid;
    ttsd_pkg::t_key     r_rd_data;
    ttsd_pkg::t_key     r_mem [0:MAX_ROWS-1];
    logic               r_out_valid;
    ttsd_pkg::t_status  r_out_status;
    logic [CW-1:0]      r_out_rows;
    logic [FW-1:0]      r_out_states;
    logic               r_out_row_ok;

    ttsd_pkg::t_kind    in_kind;
    logic [FW-1:0]      in_from;
    logic [FW-1:0]      in_label;
    logic [FW-1:0]      in_to;
    logic [IW-1:0]      idx_ext;
    ttsd_pkg::t_key     add_key;
    logic               too_big;
    logic [FW-1:0]      from_next;
    logic [FW-1:0]      to_next;
    logic [FW-1:0]      add_states;
    logic               accept;

    logic               n_open;
    logic [CW-1:0]      n_rows;
    logic [FW-1:0]      n_states;
    ttsd_pkg::t_status  step_status;
    logic               step_row_ok;
    logic               add_we;
    logic               start_sort;

    ttsd_pkg::t_cell_ctrl cell_ctrl;
    logic               head_full;
    ttsd_pkg::t_key     head_key;
    logic               keep;
    logic [CW-1:0]      w_next;
    logic               load_last;
    logic               settle_last;
    logic               drain_last;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    ttsd_pkg::t_key     mem_wdata;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [FW-1:0]      row_from;
    logic [FW-1:0]      row_label;
    logic [FW-1:0]      row_to;

    assign in_kind  = ttsd_pkg::t_kind'(s_axis_tuser);
    assign in_from  = s_axis_tdata[FW-1:0];
    assign in_label = s_axis_tdata[2*FW-1:FW];
    assign in_to    = s_axis_tdata[3*FW-1:2*FW];
    assign idx_ext  = IW'(s_axis_tdata[3*FW+ttsd_pkg::INDEX_W-1:3*FW]);
    assign add_key  = {in_from, in_label, in_to};

    assign s_axis_tready = (r_state == S_RUN) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign too_big = (in_from == ttsd_pkg::TOO_BIG) || (in_label == ttsd_pkg::TOO_BIG)
                  || (in_to == ttsd_pkg::TOO_BIG);
    assign from_next = in_from + FW'(1);
    assign to_next   = in_to + FW'(1);

    always_comb begin
        add_states = r_states;
        if (from_next > add_states) begin
            add_states = from_next;
        end
        if (to_next > add_states) begin
            add_states = to_next;
        end
    end

    always_comb begin
        n_open      = r_open;
        n_rows      = r_rows;
        n_states    = r_states;
        step_status = ttsd_pkg::STAT_OK;
        step_row_ok = 1'b0;
        add_we      = 1'b0;
        start_sort  = 1'b0;
        unique case (in_kind)
            ttsd_pkg::KIND_ADD: begin
                if (!r_open) begin
                    step_status = ttsd_pkg::STAT_MODE;
                end else if (too_big) begin
                    step_status = ttsd_pkg::STAT_RANGE;
                end else if (r_rows == FULL_ROWS) begin
                    step_status = ttsd_pkg::STAT_FULL;
                end else begin
                    add_we   = 1'b1;
                    n_rows   = r_rows + CW'(1);
                    n_states = add_states;
                end
            end
            ttsd_pkg::KIND_CLOSE: begin
                if (r_open) begin
                    if (r_rows == '0) begin
                        n_states = ttsd_pkg::EMPTY_STATES;
                        n_open   = 1'b0;
                    end else begin
                        start_sort = 1'b1;
                    end
                end
            end
            ttsd_pkg::KIND_READ: begin
                if (r_open) begin
                    step_status = ttsd_pkg::STAT_MODE;
                end else if (idx_ext >= IW'(r_rows)) begin
                    step_status = ttsd_pkg::STAT_RANGE;
                end else begin
                    step_row_ok = 1'b1;
                end
            end
            ttsd_pkg::KIND_REOPEN: begin
                n_open = 1'b1;
            end
            default: begin
                n_open = r_open;
            end
        endcase
    end

    assign cell_ctrl.clear = accept && start_sort;
    assign cell_ctrl.shift = (r_state == S_DRAIN);

    ttsd_sorter #(
        .NUM_CELLS(MAX_ROWS)
    ) u_sorter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (cell_ctrl),
        .i_in_valid (r_ld_valid),
        .i_in_key   (r_rd_data),
        .o_head_full(head_full),
        .o_head_key (head_key)
    );

    assign keep        = (r_w == '0) || (head_key != r_last);
    assign w_next      = r_w + CW'(keep);
    assign load_last   = (r_cnt + TW'(1)) == TW'(r_rows);
    assign settle_last = r_cnt == (TW'(r_rows) + TW'(2));
    assign drain_last  = (r_cnt + TW'(1)) == TW'(r_rows);

    assign mem_we    = (accept && add_we) || ((r_state == S_DRAIN) && keep);
    assign mem_waddr = (r_state == S_DRAIN) ? r_w[AW-1:0] : r_rows[AW-1:0];
    assign mem_wdata = (r_state == S_DRAIN) ? head_key : add_key;
    assign rd_en     = accept || (r_state == S_LOAD);
    assign rd_addr   = (r_state == S_LOAD) ? r_cnt[AW-1:0] : idx_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_open      <= 1'b1;
            r_rows      <= '0;
            r_states    <= '0;
            r_cnt       <= '0;
            r_w         <= '0;
            r_ld_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ld_valid <= (r_state == S_LOAD);
            if (r_out_valid && m_axis_tready && !(accept && !start_sort)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (accept) begin
                        r_open   <= n_open;
                        r_rows   <= n_rows;
                        r_states <= n_states;
                        r_cnt    <= '0;
                        r_w      <= '0;
                        if (start_sort) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= step_status;
                            r_out_rows   <= n_rows;
                            r_out_states <= n_states;
                            r_out_row_ok <= step_row_ok;
                        end
                    end
                end
                S_LOAD: begin
                    if (load_last) begin
                        r_cnt   <= '0;
                        r_state <= S_SETTLE;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                S_SETTLE: begin
                    if (settle_last) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                S_DRAIN: begin
                    r_w <= w_next;
                    if (keep) begin
                        r_last <= head_key;
                    end
                    if (drain_last) begin
                        r_rows       <= w_next;
                        r_open       <= 1'b0;
                        r_state      <= S_RUN;
                        r_out_valid  <= 1'b1;
                        r_out_status <= ttsd_pkg::STAT_OK;
                        r_out_rows   <= w_next;
                        r_out_states <= r_states;
                        r_out_row_ok <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign row_from  = r_out_row_ok ? r_rd_data[3*FW-1:2*FW] : '0;
    assign row_label = r_out_row_ok ? r_rd_data[2*FW-1:FW]   : '0;
    assign row_to    = r_out_row_ok ? r_rd_data[FW-1:0]      : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = ttsd_pkg::M_TDATA_W'({row_to, row_label, row_from, r_out_states,
                                                 ttsd_pkg::ROWC_W'(r_out_rows)});

    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= FULL_ROWS)
        else $error("row count beyond table size");

    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> head_full)
        else $error("head cell empty while draining");

    a_drain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && (r_w != '0)) |-> (head_key >= r_last))
        else $error("drained keys out of order");

    a_dedup_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && drain_last) |=> (r_rows <= $past(r_rows)))
        else $error("dedup grew the table");

    a_read_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_row_ok) |-> !r_open)
        else $error("row returned from an open table");

endmodule
